// ----- design/sha256_pkg.sv -----
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumH   = 8;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PadMarker = 8'h80;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  // Control strobes from the sequencer to the datapath units.
  typedef struct packed {
    logic shift_byte;
    logic load_work;
    logic do_round;
    logic fold;
    logic reset_h;
  } ctrl_t;

  localparam logic [31:0] InitH [NumH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- design/sha256_sched.sv -----
module sha256_sched (
  input  logic              clk_i,
  input  sha256_pkg::ctrl_t ctrl_i,
  input  logic [7:0]        byte_i,
  output logic [31:0]       w_o
);
  import sha256_pkg::*;

  // Sixteen-word window; the oldest word sits in the top bits. Bytes shift in
  // during absorb and padding, and words shift through it during the rounds.
  logic [511:0] msg_q;
  logic [31:0]  w0, w1, w9, w14, sig0, sig1, w_new;

  assign w0  = msg_q[511:480];
  assign w1  = msg_q[479:448];
  assign w9  = msg_q[223:192];
  assign w14 = msg_q[63:32];

  assign sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = sig1 + w9 + sig0 + w0;
  assign w_o   = w0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_byte) begin
      msg_q <= {msg_q[503:0], byte_i};
    end else if (ctrl_i.do_round) begin
      msg_q <= {msg_q[479:0], w_new};
    end
  end

endmodule

// ----- design/sha256_round.sv -----
module sha256_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha256_pkg::ctrl_t ctrl_i,
  input  logic [31:0]       w_i,
  input  logic [5:0]        rnd_i,
  input  logic [2:0]        rd_idx_i,
  output logic [31:0]       h_word_o
);
  import sha256_pkg::*;

  logic [31:0] h_q  [NumH];
  logic [31:0] wk_q [NumH];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  assign a = wk_q[0];
  assign b = wk_q[1];
  assign c = wk_q[2];
  assign d = wk_q[3];
  assign e = wk_q[4];
  assign f = wk_q[5];
  assign g = wk_q[6];
  assign h = wk_q[7];

  assign big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign ch     = (e & f) ^ (~e & g);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t1     = h + big_s1 + ch + RoundK[rnd_i] + w_i;
  assign t2     = big_s0 + maj;

  assign h_word_o = h_q[rd_idx_i];

  // Chaining state: resets to the initial hash values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumH; i++) h_q[i] <= InitH[i];
    end else if (ctrl_i.reset_h) begin
      for (int i = 0; i < NumH; i++) h_q[i] <= InitH[i];
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < NumH; i++) h_q[i] <= h_q[i] + wk_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_work) begin
      for (int i = 0; i < NumH; i++) wk_q[i] <= h_q[i];
    end else if (ctrl_i.do_round) begin
      wk_q[7] <= g;
      wk_q[6] <= f;
      wk_q[5] <= e;
      wk_q[4] <= d + t1;
      wk_q[3] <= c;
      wk_q[2] <= b;
      wk_q[1] <= a;
      wk_q[0] <= t1 + t2;
    end
  end

endmodule

// ----- design/sha256_hash_engine_unit.sv -----
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------
// in       | input     | in_valid_i/in_ready_o | in_req_i: cmd, data_byte
// out      | output    | out_valid_o/out_ready_i | out_req_o: digest_word, word_index,
//          |           |                       |   last_word
//
// Absorb requests are taken back to back while the block is idle. The request that
// completes a 64-byte block is followed by a busy compression: the working words
// are loaded, 64 rounds run on the single round unit, and the result is folded into
// the chaining state. A finish request shifts in one pad byte per cycle up to the
// block end (64 minus the block fill), runs the compression, repeats both for a
// second block when the length does not fit, and then hands out eight digest words.
// Reset returns the chaining state to the initial hash values and the count to zero.
// The output register lets new requests be taken while the last digest word waits;
// a stalled output only holds the block while it still has words to deliver.
module sha256_hash_engine_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sha256_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sha256_pkg::out_req_t out_req_o
);
  import sha256_pkg::*;

  state_e      state_q, state_d;
  ctrl_t       ctrl;
  logic [7:0]  shift_byte;
  logic [63:0] count_q;
  logic [5:0]  rnd_q;
  logic [5:0]  pad_pos_q;
  logic [2:0]  out_idx_q;
  logic        first_q, fin_q, final_blk_q;
  logic        out_valid_q;
  out_req_t    out_q;
  logic        in_acc, out_load;
  logic [63:0] bit_len;
  logic [7:0]  len_byte, pad_byte;
  logic [31:0] w, h_word;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Padding bytes: the marker first, then zeros, and in the final block the
  // big-endian bit length in the last eight positions.
  assign bit_len  = {count_q[60:0], 3'b000};
  assign len_byte = bit_len[{~pad_pos_q[2:0], 3'b000} +: 8];
  always_comb begin
    if (first_q) begin
      pad_byte = PadMarker;
    end else if (final_blk_q && (pad_pos_q[5:3] == 3'd7)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl       = '0;
    shift_byte = in_req_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.cmd == CMD_FINISH) begin
            state_d = ST_PAD;
          end else begin
            ctrl.shift_byte = 1'b1;
            if (count_q[5:0] == 6'd63) state_d = ST_LOAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.shift_byte = 1'b1;
        shift_byte      = pad_byte;
        if (pad_pos_q == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load_work = 1'b1;
        state_d        = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.do_round = 1'b1;
        if (rnd_q == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (final_blk_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_load && (out_idx_q == 3'd7)) begin
          ctrl.reset_h = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer counters and message length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rnd_q       <= '0;
      pad_pos_q   <= '0;
      out_idx_q   <= '0;
      first_q     <= 1'b0;
      fin_q       <= 1'b0;
      final_blk_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_req_i.cmd == CMD_FINISH) begin
              pad_pos_q   <= count_q[5:0];
              first_q     <= 1'b1;
              fin_q       <= 1'b1;
              final_blk_q <= (count_q[5:0] < 6'd56);
            end else begin
              count_q <= count_q + 64'd1;
            end
          end
        end
        ST_PAD: begin
          pad_pos_q <= pad_pos_q + 6'd1;
          first_q   <= 1'b0;
        end
        ST_LOAD:  rnd_q <= '0;
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_FOLD: begin
          if (fin_q) final_blk_q <= 1'b1;
        end
        ST_OUT: begin
          if (out_load) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              fin_q   <= 1'b0;
              count_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.digest_word <= h_word;
      out_q.word_index  <= out_idx_q;
      out_q.last_word   <= (out_idx_q == 3'd7);
    end
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .byte_i (shift_byte),
    .w_o    (w)
  );

  sha256_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_i      (w),
    .rnd_i    (rnd_q),
    .rd_idx_i (out_idx_q),
    .h_word_o (h_word)
  );

  // The last round always leads to the fold.
  a_round_to_fold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("round sequence did not end in the fold step");

  // A byte that fills the block starts a compression.
  a_full_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.cmd == CMD_ABSORB && count_q[5:0] == 6'd63) |=> (state_q == ST_LOAD))
    else $error("full block did not start a compression");

  // A finish request always goes to padding.
  a_finish_pads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.cmd == CMD_FINISH) |=> (state_q == ST_PAD && first_q))
    else $error("finish request did not start padding");

  // Digest words are only handed out after the length block.
  a_out_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (fin_q && final_blk_q))
    else $error("digest output without the final padded block");

endmodule

// ----- tb/sv/sha256_hash_engine_unit_checker.sv -----
`timescale 1ns / 1ps

module sha256_hash_engine_unit_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  sha256_pkg::in_req_t  in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  sha256_pkg::out_req_t out_req_i,
  output int                   fail_cnt_o,
  output int                   pending_o
);

  logic [31:0] chain_h   [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_len;

  sha256_pkg::out_req_t digest_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of msg_block into chain_h.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s0 = ror32(w[(t+1)%16], 7) ^ ror32(w[(t+1)%16], 18) ^ (w[(t+1)%16] >> 3);
        s1 = ror32(w[(t+14)%16], 17) ^ ror32(w[(t+14)%16], 19) ^ (w[(t+14)%16] >> 10);
        w[t%16] = s1 + w[(t+9)%16] + s0 + w[t%16];
      end
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::RoundK[t] + w[t%16];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int                   pos;
    logic [63:0]          bit_len;
    sha256_pkg::out_req_t word;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_h[i] = sha256_pkg::InitH[i];
      msg_len = '0;
      digest_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      // A finish accepted in this cycle cannot have a word out yet, so results go first.
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, actual %h/%0d/%0b", $time,
                   out_req_i.digest_word, out_req_i.word_index, out_req_i.last_word);
          fail_cnt_o++;
        end else begin
          word = digest_q.pop_front();
          if (out_req_i.digest_word !== word.digest_word ||
              out_req_i.word_index !== word.word_index ||
              out_req_i.last_word !== word.last_word) begin
            $display("%0t: digest word mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                     $time, word.digest_word, word.word_index, word.last_word,
                     out_req_i.digest_word, out_req_i.word_index, out_req_i.last_word);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pos = int'(msg_len[5:0]);
        if (in_req_i.cmd == sha256_pkg::CMD_ABSORB) begin
          msg_block[pos] = in_req_i.data_byte;
          msg_len++;
          if (pos == 63) compress_block();
        end else begin
          msg_block[pos] = sha256_pkg::PadMarker;
          pos++;
          // The length field needs eight bytes; spill into an extra block if short.
          if (pos > 56) begin
            for (int i = pos; i < 64; i++) msg_block[i] = '0;
            compress_block();
            pos = 0;
          end
          for (int i = pos; i < 56; i++) msg_block[i] = '0;
          bit_len = msg_len << 3;
          for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
          compress_block();
          for (int i = 0; i < 8; i++) begin
            word.digest_word = chain_h[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_q.push_back(word);
          end
          for (int i = 0; i < 8; i++) chain_h[i] = sha256_pkg::InitH[i];
          msg_len = '0;
        end
      end
      pending_o = digest_q.size();
    end
  end

endmodule

// ----- tb/sv/sha256_hash_engine_unit_tb.sv -----
`timescale 1ns / 1ps

module sha256_hash_engine_unit_tb;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  sha256_pkg::in_req_t  in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  sha256_pkg::out_req_t out_req_o;

  int fail_cnt;
  int words_pending;

  // Percent chances, per cycle, that the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_seq; the receiver
  // process notices the change and runs the hold-off down from hold_len on its own.
  int hold_len = 0;
  int hold_seq = 0;

  int items_sent = 0;

  // Idling mix of each random phase: none, sender mostly idle, receiver mostly
  // stalled, and both idling at a moderate rate.
  int phase_idle  [4] = '{0, 88, 0, 38};
  int phase_stall [4] = '{0, 0, 88, 38};

  always #4 clk_i = ~clk_i;

  sha256_hash_engine_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  // The checker sees both channels, predicts every digest and compares.
  sha256_hash_engine_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_i   (out_req_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (words_pending)
  );

  // Offers one request. Random idle cycles come first, with valid low; once
  // valid is raised it stays high with the same payload until the request is
  // taken. Valid is left high on return, so a request that follows directly
  // keeps it asserted without a drop.
  task automatic send_req(input sha256_pkg::cmd_e cmd, input logic [7:0] data);
    sha256_pkg::in_req_t req;
    req.cmd       = cmd;
    req.data_byte = data;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // A message of random bytes closed by a finish request. The data byte of the
  // finish request is random as well, since the block must ignore it.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_req(sha256_pkg::CMD_ABSORB, 8'($urandom_range(255)));
    send_req(sha256_pkg::CMD_FINISH, 8'($urandom_range(255)));
  endtask

  // The sender steps back until every predicted digest word has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off on request.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // The whole run is bounded by a fixed time far above the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int len;
    int sel;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The empty message comes first, then the three bytes of
    // "abc", then the extreme byte values, then a second empty message right
    // after a digest to show that the chaining state went back to its start.
    send_req(sha256_pkg::CMD_FINISH, 8'hff);
    send_req(sha256_pkg::CMD_ABSORB, 8'h61);
    send_req(sha256_pkg::CMD_ABSORB, 8'h62);
    send_req(sha256_pkg::CMD_ABSORB, 8'h63);
    send_req(sha256_pkg::CMD_FINISH, 8'h00);
    send_req(sha256_pkg::CMD_ABSORB, 8'h00);
    send_req(sha256_pkg::CMD_ABSORB, 8'hff);
    send_req(sha256_pkg::CMD_FINISH, 8'hff);
    send_req(sha256_pkg::CMD_FINISH, 8'h00);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      if (p == 0) begin
        // Hold the receiver off while short messages keep coming, so that
        // the digest words back up and the block stops taking requests.
        hold_len = 300;
        hold_seq++;
        send_message(2);
        send_message(1);
      end
      while (items_sent < 10 + 90 * (p + 1)) begin
        // Lengths favor the block boundary, where the padding needs an extra
        // block, and now and then a message spans two full blocks.
        sel = $urandom_range(9);
        if (sel < 5) len = $urandom_range(8);
        else if (sel < 9) len = $urandom_range(65, 53);
        else len = $urandom_range(129, 119);
        send_message(len);
      end
      wait_drained();
    end

    // Let any compression still under way finish, with nothing more expected.
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sha256_hash_engine_unit.f -----
design/sha256_pkg.sv
design/sha256_sched.sv
design/sha256_round.sv
design/sha256_hash_engine_unit.sv
tb/sv/sha256_hash_engine_unit_checker.sv
tb/sv/sha256_hash_engine_unit_tb.sv
